// ----- sv/psu_pkg.sv -----
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types, codes and swizzle tables of the palette slot upload planner.
// ----------------------------------------------------------------------------
package psu_pkg;

  localparam logic [15:0] FMT_16C = 16'h0013;
  localparam logic [15:0] FMT_32E = 16'h0014;

  localparam logic [1:0] STATUS_PASS   = 2'd0;
  localparam logic [1:0] STATUS_PREP   = 2'd1;
  localparam logic [1:0] STATUS_NOSLOT = 2'd2;

  localparam logic KIND_COPY = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_BANK0_SRC  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BANK1_SRC  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BANK0_IDX  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BANK1_IDX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BANK0_CAP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BANK1_CAP  = 3'd5;

  localparam logic [6:0]  LEN_16C    = 7'd64;
  localparam logic [6:0]  LEN_32E    = 7'd32;
  localparam logic [63:0] ROW_STRIDE = 64'd256;
  localparam int          ROWS_16C   = 16;
  localparam int          ROWS_32E   = 2;
  localparam int          ROW_CNT_W  = 4;

  // Swizzle tables, including the neighbor bytes at negative positions.
  localparam logic [7:0] TAB13 [16] = '{
    8'h0B, 8'h0E, 8'h0F, 8'h1A, 8'h1B, 8'h1E, 8'h1F, 8'h00,
    8'h04, 8'h10, 8'h14, 8'h08, 8'h0C, 8'h18, 8'h1C, 8'h00
  };

  localparam logic [7:0] TAB14 [64] = '{
    8'h79, 8'h16, 8'h3F, 8'hBD, 8'h1B, 8'h4F, 8'hBF, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h3F, 8'h00,
    8'h00, 8'h00, 8'h3F, 8'hAB, 8'hAA, 8'hAA, 8'h3E, 8'h00,
    8'h00, 8'h80, 8'h3E, 8'hCD, 8'hCC, 8'h4C, 8'h3E,
    8'h00, 8'h01, 8'h04, 8'h05, 8'h10, 8'h11, 8'h14, 8'h15,
    8'h02, 8'h03, 8'h06, 8'h07, 8'h12, 8'h13, 8'h16, 8'h17,
    8'h08, 8'h09, 8'h0C, 8'h0D, 8'h18, 8'h19, 8'h1C, 8'h1D,
    8'h0A, 8'h0B, 8'h0E, 8'h0F, 8'h1A, 8'h1B, 8'h1E, 8'h1F,
    8'h00
  };

  typedef struct packed {
    logic [15:0] record_format;
    logic [15:0] slot_selector;
    logic [63:0] dest_address;
    logic [15:0] home_word_in;
  } psu_in_t;

  typedef struct packed {
    logic        item_kind;
    logic [63:0] copy_dest;
    logic [63:0] copy_source;
    logic [6:0]  copy_length;
    logic [1:0]  status;
    logic [15:0] selector_out;
    logic [15:0] home_word_out;
    logic        last_item;
  } psu_out_t;

  typedef struct packed {
    logic capture;
    logic alloc;
    logic calc;
    logic load_row;
    logic load_done;
  } psu_cmd_t;

  typedef struct packed {
    logic skip_rows;
    logic last_row;
  } psu_sts_t;

endpackage

// ----- sv/psu_stream_if.sv -----
// ----------------------------------------------------------------------------
// psu_stream_if
// Valid/ready stream channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface psu_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/psu_datapath.sv -----
// ----------------------------------------------------------------------------
// psu_datapath
// Configuration registers, slot counters, address and home word arithmetic,
// and the output register.
// ----------------------------------------------------------------------------
module psu_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [psu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psu_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  psu_pkg::psu_in_t                in_data,
  input  psu_pkg::psu_cmd_t               cmd,
  output psu_pkg::psu_sts_t               sts,
  output psu_pkg::psu_out_t               out_data
);

  logic [63:0]        bank0_src_r, bank1_src_r;
  logic signed [15:0] bank0_idx_r, bank1_idx_r;
  logic [15:0]        bank0_cap_r, bank1_cap_r;
  logic [15:0]        next_slot_r [2];

  logic        pass_r, wide_r;
  logic [15:0] sel_r, home_r, ci_r, home_out_r;
  logic [63:0] dst_r, src_r;
  logic [1:0]  status_r;
  logic [psu_pkg::ROW_CNT_W-1:0] rows_left_r;
  psu_pkg::psu_out_t out_r;

  logic [15:0] cand, cap;
  logic        exhausted, alloc_ok;

  logic        negc;
  logic [15:0] magc;
  logic [63:0] dm, src_base, src_calc;

  logic        negs;
  logic [15:0] mags, qs, terms, base_v, swz;
  logic [3:0]  t13i;
  logic [5:0]  t14i;
  logic [7:0]  tab_v;
  logic [6:0]  len;

  assign cand      = next_slot_r[wide_r];
  assign cap       = wide_r ? bank1_cap_r : bank0_cap_r;
  assign exhausted = (cand >= cap);
  assign alloc_ok  = !pass_r && sel_r[15] && !exhausted;
  assign len       = wide_r ? psu_pkg::LEN_32E : psu_pkg::LEN_16C;

  assign sts.skip_rows = pass_r || (sel_r[15] && exhausted);
  assign sts.last_row  = (rows_left_r == '0);

  always_comb begin
    negc     = ci_r[15];
    magc     = negc ? (~ci_r + 16'd1) : ci_r;
    if (wide_r) begin
      dm = 64'({magc[15:3], 3'b000, magc[2:0], 5'b00000});
    end else begin
      dm = 64'({magc[15:2], 4'b0000, magc[1:0], 6'b000000});
    end
    src_base = wide_r ? bank1_src_r : bank0_src_r;
    src_calc = negc ? (src_base - dm) : (src_base + dm);
  end

  always_comb begin
    negs   = sel_r[15];
    mags   = negs ? (~sel_r + 16'd1) : sel_r;
    base_v = wide_r ? bank1_idx_r : bank0_idx_r;
    t13i   = '0;
    t14i   = '0;
    if (wide_r) begin
      qs    = {mags[15:5], 5'b00000};
      t14i  = negs ? (6'd31 - {1'b0, mags[4:0]}) : (6'd31 + {1'b0, mags[4:0]});
      tab_v = psu_pkg::TAB14[t14i];
    end else begin
      qs    = {mags[13:3], 5'b00000};
      t13i  = negs ? (4'd7 - {1'b0, mags[2:0]}) : (4'd7 + {1'b0, mags[2:0]});
      tab_v = psu_pkg::TAB13[t13i];
    end
    terms = negs ? (~qs + 16'd1) : qs;
    swz   = base_v + terms + {{8{tab_v[7]}}, tab_v};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank0_src_r    <= '0;
      bank1_src_r    <= '0;
      bank0_idx_r    <= '0;
      bank1_idx_r    <= '0;
      bank0_cap_r    <= '0;
      bank1_cap_r    <= '0;
      next_slot_r[0] <= '0;
      next_slot_r[1] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          psu_pkg::REG_BANK0_SRC: bank0_src_r <= cfg_wdata;
          psu_pkg::REG_BANK1_SRC: bank1_src_r <= cfg_wdata;
          psu_pkg::REG_BANK0_IDX: bank0_idx_r <= cfg_wdata[15:0];
          psu_pkg::REG_BANK1_IDX: bank1_idx_r <= cfg_wdata[15:0];
          psu_pkg::REG_BANK0_CAP: bank0_cap_r <= cfg_wdata[15:0];
          psu_pkg::REG_BANK1_CAP: bank1_cap_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (cmd.alloc && alloc_ok) begin
        next_slot_r[wide_r] <= cand + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pass_r <= (in_data.record_format != psu_pkg::FMT_16C) &&
                (in_data.record_format != psu_pkg::FMT_32E);
      wide_r <= (in_data.record_format == psu_pkg::FMT_32E);
      sel_r  <= in_data.slot_selector;
      dst_r  <= in_data.dest_address;
      home_r <= in_data.home_word_in;
    end
    if (cmd.alloc) begin
      if (pass_r) begin
        status_r   <= psu_pkg::STATUS_PASS;
        home_out_r <= home_r;
      end else if (sel_r[15]) begin
        if (exhausted) begin
          status_r   <= psu_pkg::STATUS_NOSLOT;
          home_out_r <= '0;
        end else begin
          status_r <= psu_pkg::STATUS_PREP;
          sel_r    <= cand;
          ci_r     <= cand;
        end
      end else begin
        status_r <= psu_pkg::STATUS_PREP;
        ci_r     <= home_r;
      end
    end
    if (cmd.calc) begin
      src_r       <= src_calc;
      home_out_r  <= swz;
      rows_left_r <= wide_r ? psu_pkg::ROW_CNT_W'(psu_pkg::ROWS_32E - 1)
                            : psu_pkg::ROW_CNT_W'(psu_pkg::ROWS_16C - 1);
    end
    if (cmd.load_row) begin
      out_r.item_kind     <= psu_pkg::KIND_COPY;
      out_r.copy_dest     <= dst_r;
      out_r.copy_source   <= src_r;
      out_r.copy_length   <= len;
      out_r.status        <= psu_pkg::STATUS_PREP;
      out_r.selector_out  <= '0;
      out_r.home_word_out <= '0;
      out_r.last_item     <= 1'b0;
      dst_r       <= dst_r + 64'(len);
      src_r       <= src_r + psu_pkg::ROW_STRIDE;
      rows_left_r <= rows_left_r - 1'b1;
    end
    if (cmd.load_done) begin
      out_r.item_kind     <= psu_pkg::KIND_DONE;
      out_r.copy_dest     <= '0;
      out_r.copy_source   <= '0;
      out_r.copy_length   <= '0;
      out_r.status        <= status_r;
      out_r.selector_out  <= sel_r;
      out_r.home_word_out <= home_out_r;
      out_r.last_item     <= 1'b1;
    end
  end

  assign out_data = out_r;

endmodule

// ----- sv/psu_ctrl.sv -----
// ----------------------------------------------------------------------------
// psu_ctrl
// Sequencer of one record: capture, slot allocation, address setup, copy
// rows and the completion item, plus the output register's valid flag.
// ----------------------------------------------------------------------------
module psu_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  psu_pkg::psu_sts_t  sts,
  output psu_pkg::psu_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_CALC,
    S_ROWS,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_ALLOC;
        end
      end
      S_ALLOC: begin
        cmd.alloc = 1'b1;
        state_nxt = sts.skip_rows ? S_DONE : S_CALC;
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_ROWS;
      end
      S_ROWS: begin
        if (slot_free) begin
          cmd.load_row = 1'b1;
          if (sts.last_row) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.load_done = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.load_row || cmd.load_done) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_capture_to_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_ALLOC))
    else $error("accepted record did not move to allocation");

  a_alloc_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALLOC) |=> (state_r == S_CALC || state_r == S_DONE))
    else $error("allocation step left to an unexpected state");

  a_done_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_done |=> (out_valid_r && state_r == S_IDLE))
    else $error("completion item not presented after load");

  a_last_row_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_row && sts.last_row) |=> (state_r == S_DONE))
    else $error("last copy row did not lead to completion");

endmodule

// ----- sv/palette_slot_upload_planner.sv -----
// ----------------------------------------------------------------------------
// palette_slot_upload_planner
// Turns one palette record into a run of copy commands and a completion item.
// A record is taken only while the sequencer is idle; the completion item of
// the previous record may still sit in the output register. A passthrough
// record or one that finds no free slot goes from capture and slot
// allocation to its completion item. A 32-entry record (format 0x14) or a
// 16-color record (format 0x13) goes through capture, slot allocation,
// address setup, then one item per cycle through the single output register
// while the output does not stall. The user writes configuration through
// cfg_we, cfg_index and cfg_wdata while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module palette_slot_upload_planner (
  input  logic                            clk,
  input  logic                            rst_n,
  psu_stream_if.sink                      in_ch,
  psu_stream_if.source                    out_ch,
  input  logic                            cfg_we,
  input  logic [psu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psu_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  psu_pkg::psu_cmd_t cmd;
  psu_pkg::psu_sts_t sts;

  psu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  psu_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_ch.payload),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_ch.payload)
  );

endmodule
